// ===== rtl/psort_pkg.sv =====
`timescale 1ns / 1ps

package psort_pkg;

  localparam int MAX_POINTS  = 64;
  localparam int COORD_BITS  = 16;
  localparam int KEY_BITS    = 2 * COORD_BITS;
  localparam int CNT_BITS    = $clog2(MAX_POINTS + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [KEY_BITS-1:0]          key_t;
  typedef logic [CNT_BITS-1:0]          count_t;
  typedef logic [QPTR_BITS-1:0]         qptr_t;
  typedef logic [QCNT_BITS-1:0]         qcount_t;

  // What the back end does with a queued item
  typedef enum logic {
    OP_INSERT,
    OP_DROP
  } op_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    key_t   key;
    op_t    op;
    logic   last;
  } qentry_t;

  typedef enum logic {
    BK_COLLECT,
    BK_EMIT
  } back_state_t;

endpackage

// ===== rtl/psort_ifs.sv =====
`timescale 1ns / 1ps

interface psort_point_if;
  logic                 valid;
  logic                 ready;
  psort_pkg::coord_t    point_x;
  psort_pkg::coord_t    point_y;
  logic                 set_end;

  modport source (output valid, output point_x, output point_y, output set_end,
                  input ready);
  modport sink   (input valid, input point_x, input point_y, input set_end,
                  output ready);
endinterface

interface psort_sorted_if;
  logic                 valid;
  logic                 ready;
  psort_pkg::coord_t    sorted_x;
  psort_pkg::coord_t    sorted_y;
  logic                 run_last;
  logic                 points_dropped;

  modport source (output valid, output sorted_x, output sorted_y, output run_last,
                  output points_dropped, input ready);
  modport sink   (input valid, input sorted_x, input sorted_y, input run_last,
                  input points_dropped, output ready);
endinterface

// ===== rtl/point_magnitude_sorter_core.sv =====
`timescale 1ns / 1ps

// Channel   Dir  Payload                                          Handshake
// points    in   point_x, point_y (signed Q11.4), set_end          valid/ready
// sorted    out  sorted_x, sorted_y, run_last, points_dropped      valid/ready
//
// Front end takes one point per cycle while the queue has room: squares
// registered, key summed into a four-entry queue. Back end pops one item per
// cycle into a 64-cell insertion chain while collecting; after a set's end item
// it drains the chain one point per cycle into the output register while sorted is
// ready. Further items wait in the queue during the drain.
// Reset (rst, synchronous) empties the front-end register, queue, chain count and output register.
// Stalls on sorted hold the chain; points backs up once the queue fills.

module point_magnitude_sorter_core (
  input  logic            clk,
  input  logic            rst,
  psort_point_if.sink     points,
  psort_sorted_if.source  sorted
);

  psort_pkg::qentry_t  q_wdata;
  psort_pkg::qentry_t  q_rdata;
  logic                q_push;
  logic                q_full;
  logic                q_valid;
  logic                q_pop;

  // classify each point (insert or drop) and compute its squared distance
  psort_front u_front (
    .clk     (clk),
    .rst     (rst),
    .points  (points),
    .q_wdata (q_wdata),
    .q_push  (q_push),
    .q_full  (q_full)
  );

  // decouple the front end from the chain while a run drains
  psort_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .wdata    (q_wdata),
    .full     (q_full),
    .rd_valid (q_valid),
    .rdata    (q_rdata),
    .pop      (q_pop)
  );

  // insert into key order, then emit the run from the head
  psort_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_rdata (q_rdata),
    .q_pop   (q_pop),
    .sorted  (sorted)
  );

endmodule

// ===== rtl/psort_front.sv =====
`timescale 1ns / 1ps

module psort_front (
  input  logic                 clk,
  input  logic                 rst,
  psort_point_if.sink          points,
  output psort_pkg::qentry_t   q_wdata,
  output logic                 q_push,
  input  logic                 q_full
);

  logic                            s_vld;
  psort_pkg::coord_t               s_x;
  psort_pkg::coord_t               s_y;
  logic [psort_pkg::KEY_BITS-1:0]  s_xx;
  logic [psort_pkg::KEY_BITS-1:0]  s_yy;
  psort_pkg::op_t                  s_op;
  logic                            s_last;
  psort_pkg::count_t               count;

  logic                                   accept;
  logic                                   full_set;
  logic signed [psort_pkg::KEY_BITS-1:0]  xe;
  logic signed [psort_pkg::KEY_BITS-1:0]  ye;
  logic signed [psort_pkg::KEY_BITS-1:0]  xx;
  logic signed [psort_pkg::KEY_BITS-1:0]  yy;

  assign q_push       = s_vld && !q_full;
  assign points.ready = !s_vld || !q_full;
  assign accept       = points.valid && points.ready;
  assign full_set     = (count == psort_pkg::count_t'(psort_pkg::MAX_POINTS));

  always_comb begin
    xe = {{psort_pkg::COORD_BITS{points.point_x[psort_pkg::COORD_BITS-1]}}, points.point_x};
    ye = {{psort_pkg::COORD_BITS{points.point_y[psort_pkg::COORD_BITS-1]}}, points.point_y};
    xx = xe * xe;
    yy = ye * ye;
  end

  // squares are registered; the sum goes straight into the queue
  always_comb begin
    q_wdata.x    = s_x;
    q_wdata.y    = s_y;
    q_wdata.key  = s_xx + s_yy;
    q_wdata.op   = s_op;
    q_wdata.last = s_last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_vld <= 1'b0;
      count <= '0;
    end else begin
      if (accept) begin
        s_vld <= 1'b1;
        if (points.set_end) begin
          count <= '0;
        end else if (!full_set) begin
          count <= count + 1'b1;
        end
      end else if (q_push) begin
        s_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_x    <= points.point_x;
      s_y    <= points.point_y;
      s_xx   <= psort_pkg::key_t'(xx);
      s_yy   <= psort_pkg::key_t'(yy);
      s_op   <= full_set ? psort_pkg::OP_DROP : psort_pkg::OP_INSERT;
      s_last <= points.set_end;
    end
  end

endmodule

// ===== rtl/psort_queue.sv =====
`timescale 1ns / 1ps

module psort_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  psort_pkg::qentry_t   wdata,
  output logic                 full,
  output logic                 rd_valid,
  output psort_pkg::qentry_t   rdata,
  input  logic                 pop
);

  psort_pkg::qentry_t  entries [psort_pkg::QUEUE_DEPTH];
  psort_pkg::qptr_t    wr_ptr;
  psort_pkg::qptr_t    rd_ptr;
  psort_pkg::qcount_t  fill;

  assign full     = (fill == psort_pkg::qcount_t'(psort_pkg::QUEUE_DEPTH));
  assign rd_valid = (fill != '0);
  assign rdata    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= wdata;
    end
  end

endmodule

// ===== rtl/psort_back.sv =====
`timescale 1ns / 1ps

module psort_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  input  psort_pkg::qentry_t   q_rdata,
  output logic                 q_pop,
  psort_sorted_if.source       sorted
);

  localparam int N = psort_pkg::MAX_POINTS;

  // insertion chain, kept in ascending key order
  psort_pkg::coord_t  cx  [N];
  psort_pkg::coord_t  cy  [N];
  psort_pkg::key_t    ck  [N];

  psort_pkg::count_t       count;
  logic                    overflow;
  psort_pkg::back_state_t  state;
  psort_pkg::back_state_t  state_next;

  logic               o_vld;
  psort_pkg::coord_t  o_x;
  psort_pkg::coord_t  o_y;
  logic               o_last;
  logic               o_drop;

  logic          do_ins;
  logic          do_drop;
  logic          load;
  logic          at_last;
  logic [N-1:0]  gt;
  logic [N-1:0]  ins_here;

  assign at_last = (count == psort_pkg::count_t'(1));

  always_comb begin
    state_next = state;
    case (state)
      psort_pkg::BK_COLLECT: begin
        if (q_valid && q_rdata.last) begin
          state_next = psort_pkg::BK_EMIT;
        end
      end
      psort_pkg::BK_EMIT: begin
        if (load && at_last) begin
          state_next = psort_pkg::BK_COLLECT;
        end
      end
      default: state_next = psort_pkg::BK_COLLECT;
    endcase
  end

  always_comb begin
    q_pop   = 1'b0;
    load    = 1'b0;
    case (state)
      psort_pkg::BK_COLLECT: q_pop = q_valid;
      psort_pkg::BK_EMIT:    load  = !o_vld || sorted.ready;
      default: begin
        q_pop = 1'b0;
        load  = 1'b0;
      end
    endcase
  end

  assign do_ins  = q_pop && (q_rdata.op == psort_pkg::OP_INSERT);
  assign do_drop = q_pop && (q_rdata.op == psort_pkg::OP_DROP);

  // empty cells count as larger than any key; equal keys stay ahead
  always_comb begin
    for (int i = 0; i < N; i++) begin
      gt[i] = (psort_pkg::count_t'(i) >= count) || (ck[i] > q_rdata.key);
    end
  end

  for (genvar g = 0; g < N; g++) begin : g_cell
    if (g == 0) begin : g_head
      assign ins_here[g] = gt[g];
    end else begin : g_body
      assign ins_here[g] = gt[g] && !gt[g-1];
    end

    always_ff @(posedge clk) begin
      if (do_ins && gt[g]) begin
        if (ins_here[g]) begin
          cx[g] <= q_rdata.x;
          cy[g] <= q_rdata.y;
          ck[g] <= q_rdata.key;
        end else begin
          cx[g] <= cx[(g > 0) ? g - 1 : 0];
          cy[g] <= cy[(g > 0) ? g - 1 : 0];
          ck[g] <= ck[(g > 0) ? g - 1 : 0];
        end
      end else if (load) begin
        // advance the chain toward the head
        cx[g] <= cx[(g < N - 1) ? g + 1 : g];
        cy[g] <= cy[(g < N - 1) ? g + 1 : g];
        ck[g] <= ck[(g < N - 1) ? g + 1 : g];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= psort_pkg::BK_COLLECT;
      count    <= '0;
      overflow <= 1'b0;
      o_vld    <= 1'b0;
    end else begin
      state <= state_next;
      if (do_ins) begin
        count <= count + 1'b1;
      end else if (load) begin
        count <= count - 1'b1;
      end
      if (do_drop) begin
        overflow <= 1'b1;
      end else if (load && at_last) begin
        overflow <= 1'b0;
      end
      if (load) begin
        o_vld <= 1'b1;
      end else if (sorted.ready) begin
        o_vld <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      o_x    <= cx[0];
      o_y    <= cy[0];
      o_last <= at_last;
      o_drop <= overflow;
    end
  end

  assign sorted.valid          = o_vld;
  assign sorted.sorted_x       = o_x;
  assign sorted.sorted_y       = o_y;
  assign sorted.run_last       = o_last;
  assign sorted.points_dropped = o_drop;

`ifndef NO_ASSERTIONS
  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= psort_pkg::count_t'(psort_pkg::MAX_POINTS))
    else $error("chain holds more points than it has cells");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    (count >= psort_pkg::count_t'(2)) |-> (ck[0] <= ck[1]))
    else $error("chain head out of key order");

  a_run_close: assert property (@(posedge clk) disable iff (rst)
    (load && at_last) |=> (state == psort_pkg::BK_COLLECT) && (count == '0) && !overflow)
    else $error("run did not close after its last point");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == psort_pkg::BK_EMIT) |-> (count != '0))
    else $error("emitting from an empty chain");
`endif

endmodule

// ===== verif/point_magnitude_sorter_core_test.sv =====
`timescale 1ns / 1ps

// Sends sets of points into the sorter. A scoreboard keeps its own sorted copy
// of each set and checks every emitted point against it in order.
module point_magnitude_sorter_core_test;

  // Watchdog bound for the whole simulation
  localparam int CYCLE_LIMIT  = 200000;
  // Cycles to watch the output after the last expected point has arrived
  localparam int DRAIN_TAIL   = 40;
  localparam int TARGET_ITEMS = 210;
  // Stop printing mismatch lines past this many; keep counting them
  localparam int PRINT_LIMIT  = 50;

  // One point of the set that is being collected, with its squared distance
  typedef struct {
    psort_pkg::coord_t x;
    psort_pkg::coord_t y;
    longint unsigned   dist_sq;
  } held_point_t;

  // One point of a sorted run as the block should emit it
  typedef struct {
    psort_pkg::coord_t x;
    psort_pkg::coord_t y;
    logic              run_last;
    logic              points_dropped;
  } sorted_point_t;

  // Tracks the open set and the sorted points still owed by the block
  class sort_scoreboard;
    held_point_t   held[$];
    bit            overflow;
    sorted_point_t owed[$];
    int            errors;

    function new();
      overflow = 1'b0;
      errors   = 0;
    endfunction

    task report(input string what);
      if (errors < PRINT_LIMIT)
        $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    function int pending();
      return owed.size();
    endfunction

    // Place an accepted point by distance; equal distances keep arrival order.
    // On the set's end, release the whole sorted run as expected output.
    function void note_point(input psort_pkg::coord_t x, input psort_pkg::coord_t y,
                             input logic set_end);
      held_point_t   rec;
      sorted_point_t res;
      int            pos;
      if (held.size() < psort_pkg::MAX_POINTS) begin
        rec.x       = x;
        rec.y       = y;
        rec.dist_sq = longint'(x) * longint'(x) + longint'(y) * longint'(y);
        pos = held.size();
        while (pos > 0 && held[pos-1].dist_sq > rec.dist_sq)
          pos--;
        held.insert(pos, rec);
      end else begin
        overflow = 1'b1;
      end
      if (set_end) begin
        foreach (held[i]) begin
          res.x              = held[i].x;
          res.y              = held[i].y;
          res.run_last       = (i == held.size() - 1);
          res.points_dropped = overflow;
          owed.insert(owed.size(), res);
        end
        held.delete();
        overflow = 1'b0;
      end
    endfunction

    task check_result(input psort_pkg::coord_t x, input psort_pkg::coord_t y,
                      input logic run_last, input logic points_dropped);
      sorted_point_t want;
      if (owed.size() == 0) begin
        report($sformatf("unexpected point (%0d, %0d)", x, y));
      end else begin
        want = owed.pop_front();
        if (x !== want.x)
          report($sformatf("sorted_x %0d, want %0d", x, want.x));
        if (y !== want.y)
          report($sformatf("sorted_y %0d, want %0d", y, want.y));
        if (run_last !== want.run_last)
          report($sformatf("run_last %b, want %b", run_last, want.run_last));
        if (points_dropped !== want.points_dropped)
          report($sformatf("points_dropped %b, want %b", points_dropped,
                           want.points_dropped));
      end
    endtask
  endclass

  logic clk;
  logic rst;

  psort_point_if  points_ch ();
  psort_sorted_if sorted_ch ();

  point_magnitude_sorter_core dut (
    .clk    (clk),
    .rst    (rst),
    .points (points_ch.sink),
    .sorted (sorted_ch.source)
  );

  sort_scoreboard sb;
  int             items_sent;
  int             cycles;
  // While set, a side runs without gaps; each side flips its own flag now and then
  bit             send_calm;
  bit             recv_calm;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Draw the wait before the next item; a calm side does not wait at all
  function automatic int draw_wait(inout bit calm);
    if ($urandom_range(0, 15) == 0)
      calm = !calm;
    return calm ? 0 : $urandom_range(0, 8);
  endfunction

  // Hold a point on the input until it is taken, idling first as drawn
  task automatic send_point(input psort_pkg::coord_t x, input psort_pkg::coord_t y,
                            input logic last_pt);
    int gap;
    gap = draw_wait(send_calm);
    if (gap > 0) begin
      points_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    points_ch.valid   <= 1'b1;
    points_ch.point_x <= x;
    points_ch.point_y <= y;
    points_ch.set_end <= last_pt;
    do @(posedge clk); while (!(points_ch.valid && points_ch.ready));
    sb.note_point(x, y, last_pt);
    items_sent++;
  endtask

  // Draw a coordinate: full range, or a narrow span that produces many ties
  function automatic psort_pkg::coord_t draw_coord(input bit narrow);
    if (narrow)
      return psort_pkg::coord_t'($urandom_range(0, 6)) - psort_pkg::coord_t'(3);
    return psort_pkg::coord_t'($urandom_range(0, 65535));
  endfunction

  // Send a set of n random points, set_end on the last one
  task automatic send_set(input int n);
    bit narrow;
    narrow = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++)
      send_point(draw_coord(narrow), draw_coord(narrow), i == n - 1);
  endtask

  // Receive sorted points with random stalls and check each one
  initial begin
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = draw_wait(recv_calm);
      if (stall > 0) begin
        sorted_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      sorted_ch.ready <= 1'b1;
      do @(posedge clk); while (!(sorted_ch.valid && sorted_ch.ready));
      sb.check_result(sorted_ch.sorted_x, sorted_ch.sorted_y, sorted_ch.run_last,
                      sorted_ch.points_dropped);
    end
  end

  // Abort a run that hangs
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("watchdog: cycle limit reached with %0d points owed", sb.pending());
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int set_idx;
    int n;
    sb         = new();
    items_sent = 0;
    cycles     = 0;
    send_calm  = 1'b0;
    recv_calm  = 1'b0;

    rst               <= 1'b1;
    points_ch.valid   <= 1'b0;
    points_ch.point_x <= '0;
    points_ch.point_y <= '0;
    points_ch.set_end <= 1'b0;
    sorted_ch.ready   <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Single-point set at the origin
    send_point(16'sd0, 16'sd0, 1'b1);

    // Coordinate extremes, the largest possible distance, and a four-way tie
    // plus a two-way tie that must come out in arrival order
    send_point(-16'sd32768, -16'sd32768, 1'b0);
    send_point(16'sd32767, 16'sd32767, 1'b0);
    send_point(16'sd1, 16'sd0, 1'b0);
    send_point(16'sd0, 16'sd1, 1'b0);
    send_point(-16'sd1, 16'sd0, 1'b0);
    send_point(16'sd0, -16'sd1, 1'b0);
    send_point(-16'sd32768, 16'sd0, 1'b0);
    send_point(16'sd0, -16'sd32768, 1'b0);
    send_point(16'sd0, 16'sd0, 1'b0);
    send_point(16'sd32767, -16'sd32768, 1'b1);

    // Arrival in descending distance: the chain must reverse it
    send_point(16'sd100, 16'sd100, 1'b0);
    send_point(16'sd3, 16'sd4, 1'b1);

    // Identical points
    send_point(16'sd5, -16'sd5, 1'b0);
    send_point(16'sd5, -16'sd5, 1'b0);
    send_point(16'sd5, -16'sd5, 1'b1);

    // Random sets, mostly short; one exactly fills the store and one
    // overflows it so that the end point itself is dropped
    set_idx = 0;
    while (items_sent < TARGET_ITEMS || set_idx <= 7) begin
      if (set_idx == 3)
        n = psort_pkg::MAX_POINTS;
      else if (set_idx == 7)
        n = psort_pkg::MAX_POINTS + $urandom_range(1, 4);
      else
        n = $urandom_range(1, 12);
      send_set(n);
      set_idx++;
    end
    points_ch.valid <= 1'b0;

    // Drain everything owed, then watch for stray output
    while (sb.pending() != 0)
      @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);

    if (sb.errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/psort_pkg.sv
rtl/psort_ifs.sv
rtl/psort_front.sv
rtl/psort_queue.sv
rtl/psort_back.sv
rtl/point_magnitude_sorter_core.sv
verif/point_magnitude_sorter_core_test.sv
